// File: hdl/tgsm_pkg.sv
// ----------------------------------------------------------------------------
// Thermal group safety monitor package
// Shared types, register indexes, mode codes and timing constants.
// ----------------------------------------------------------------------------
package tgsm_pkg;

   localparam logic [31:0] TIMEOUT_TICKS = 32'd5000;
   localparam logic [31:0] KICK_TICKS    = 32'd1000;

   localparam logic signed [15:0] TEMP_LOW  = -16'sd20000;
   localparam logic signed [15:0] TEMP_HIGH = 16'sd20000;

   localparam logic signed [15:0] OPEN_CODE_RESET = -16'sd32768;

   typedef enum logic [2:0] {
      MODE_IDLE         = 3'd0,
      MODE_FANON        = 3'd1,
      MODE_HEAT_AUTO    = 3'd2,
      MODE_COOL_PELTIER = 3'd3,
      MODE_TEMP_RAMP    = 3'd4,
      MODE_TEMP_RAMP_QC = 3'd5,
      MODE_DRIVE_PWM_QC = 3'd6,
      MODE_OTHER        = 3'd7
   } mode_type;

   typedef enum logic [2:0] {
      CSR_THRESHOLD_A = 3'd0,
      CSR_THRESHOLD_B = 3'd1,
      CSR_PERIOD_A    = 3'd2,
      CSR_PERIOD_B    = 3'd3,
      CSR_RISE_A      = 3'd4,
      CSR_RISE_B      = 3'd5,
      CSR_OPEN_CODE   = 3'd6,
      CSR_UNUSED      = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [1:0][15:0] threshold;
      logic [1:0][31:0]        period;
      logic signed [1:0][15:0] rise;
      logic signed [15:0]      open_code;
   } cfg_type;

   typedef struct packed {
      logic               group;
      logic signed [15:0] temperature;
      logic [2:0]         mode_in;
      logic               heat_drive;
      logic               heater_present;
      logic [31:0]        sample_time;
      logic [31:0]        now_tick;
   } item_type;

   typedef struct packed {
      logic       sensor_valid;
      logic       device_is_heater;
      logic [2:0] mode_out;
      logic       open_fault;
      logic       timeout_fault;
      logic       wake_control;
      logic       slope_fault;
      logic       threshold_fault;
   } result_type;

   typedef struct packed {
      logic        armed;
      logic [31:0] start_tick;
      logic [15:0] start_temp;
   } slope_state_type;

   // load rewrites the group's slope state with armed, start_tick, start_temp.
   typedef struct packed {
      logic        load;
      logic        armed;
      logic [31:0] start_tick;
      logic [15:0] start_temp;
   } slope_update_type;

   function automatic logic mode_active(input logic [2:0] m);
      return (m >= MODE_HEAT_AUTO) && (m <= MODE_DRIVE_PWM_QC);
   endfunction

endpackage

// File: hdl/tgsm_csr.sv
// ----------------------------------------------------------------------------
// Thermal group safety monitor configuration registers
// Holds thresholds, slope windows, minimum rises and the open-sensor code.
// ----------------------------------------------------------------------------
module tgsm_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [2:0]           csr_index,
   input  logic [31:0]          csr_write_data,
   output tgsm_pkg::cfg_type    cfg
);

   tgsm_pkg::cfg_type cfg_ff;
   tgsm_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (tgsm_pkg::csr_index_type'(csr_index))
            tgsm_pkg::CSR_THRESHOLD_A: cfg_in.threshold[0] = csr_write_data[15:0];
            tgsm_pkg::CSR_THRESHOLD_B: cfg_in.threshold[1] = csr_write_data[15:0];
            tgsm_pkg::CSR_PERIOD_A:    cfg_in.period[0]    = csr_write_data;
            tgsm_pkg::CSR_PERIOD_B:    cfg_in.period[1]    = csr_write_data;
            tgsm_pkg::CSR_RISE_A:      cfg_in.rise[0]      = csr_write_data[15:0];
            tgsm_pkg::CSR_RISE_B:      cfg_in.rise[1]      = csr_write_data[15:0];
            tgsm_pkg::CSR_OPEN_CODE:   cfg_in.open_code    = csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff           <= '0;
         cfg_ff.open_code <= tgsm_pkg::OPEN_CODE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hdl/tgsm_slope.sv
// ----------------------------------------------------------------------------
// Thermal group safety monitor slope state
// Per-group start tick, start temperature and armed flag.
// ----------------------------------------------------------------------------
module tgsm_slope (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          commit,
   input  logic                          group,
   input  tgsm_pkg::slope_update_type    update,
   output tgsm_pkg::slope_state_type     state
);

   logic [1:0]        armed_ff;
   logic [1:0][31:0]  start_tick_ff;
   logic [1:0][15:0]  start_temp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= '0;
      end else if (commit && update.load) begin
         armed_ff[group] <= update.armed;
      end
   end

   // The start values only matter while the group is armed.
   always_ff @(posedge clock) begin
      if (commit && update.load) begin
         start_tick_ff[group] <= update.start_tick;
         start_temp_ff[group] <= update.start_temp;
      end
   end

   assign state.armed      = armed_ff[group];
   assign state.start_tick = start_tick_ff[group];
   assign state.start_temp = start_temp_ff[group];

endmodule

// File: hdl/tgsm_check.sv
// ----------------------------------------------------------------------------
// Thermal group safety monitor check logic
// Range check, mode forcing and the four fault checks for one item.
// ----------------------------------------------------------------------------
module tgsm_check (
   input  tgsm_pkg::item_type          item,
   input  tgsm_pkg::cfg_type           cfg,
   input  tgsm_pkg::slope_state_type   slope,
   output tgsm_pkg::result_type        result,
   output tgsm_pkg::slope_update_type  update
);

   logic signed [15:0] temp;
   logic signed [15:0] threshold;
   logic signed [16:0] rise_ext;
   logic signed [16:0] diff;
   logic [31:0]        period;
   logic [31:0]        age;
   logic [31:0]        window_age;
   logic [2:0]         mode_open;
   logic [2:0]         mode_dev;
   logic [2:0]         mode_tout;
   logic               open_f;
   logic               tout_f;
   logic               wake_f;
   logic               qualify;
   logic               slope_f;
   logic               thr_f;

   assign temp      = item.temperature;
   assign threshold = cfg.threshold[item.group];
   assign period    = cfg.period[item.group];
   assign rise_ext  = {cfg.rise[item.group][15], cfg.rise[item.group]};
   assign diff      = {temp[15], temp} - {slope.start_temp[15], slope.start_temp};
   assign age       = item.now_tick - item.sample_time;
   assign window_age = item.now_tick - slope.start_tick;

   always_comb begin
      open_f   = tgsm_pkg::mode_active(item.mode_in) && (temp == cfg.open_code);
      mode_open = open_f ? tgsm_pkg::MODE_FANON : item.mode_in;

      // Match the mode to the fitted device: heaters run auto, peltiers pelt.
      mode_dev = mode_open;
      if ((mode_dev == tgsm_pkg::MODE_COOL_PELTIER) && item.heater_present) begin
         mode_dev = tgsm_pkg::MODE_HEAT_AUTO;
      end
      if ((mode_dev == tgsm_pkg::MODE_HEAT_AUTO) && !item.heater_present) begin
         mode_dev = tgsm_pkg::MODE_COOL_PELTIER;
      end

      tout_f = tgsm_pkg::mode_active(mode_dev) && (age > tgsm_pkg::TIMEOUT_TICKS);
      wake_f = tgsm_pkg::mode_active(mode_dev) && !tout_f
               && (age > tgsm_pkg::KICK_TICKS);
      mode_tout = tout_f ? tgsm_pkg::MODE_FANON : mode_dev;

      qualify = tgsm_pkg::mode_active(mode_tout) && item.heat_drive && (period != 32'd0);
      slope_f = qualify && slope.armed && (window_age >= period) && (diff < rise_ext);

      // An unqualified check disarms; the first qualified one arms.
      update.load       = !qualify || !slope.armed;
      update.armed      = qualify;
      update.start_tick = qualify ? item.sample_time : 32'd0;
      update.start_temp = qualify ? item.temperature : 16'd0;

      thr_f = temp > threshold;

      result.sensor_valid     = (temp >= tgsm_pkg::TEMP_LOW) && (temp <= tgsm_pkg::TEMP_HIGH);
      result.device_is_heater = item.heater_present;
      result.mode_out         = (slope_f || thr_f) ? tgsm_pkg::MODE_FANON : mode_tout;
      result.open_fault       = open_f;
      result.timeout_fault    = tout_f;
      result.wake_control     = wake_f;
      result.slope_fault      = slope_f;
      result.threshold_fault  = thr_f;
   end

endmodule

// File: hdl/thermal_group_safety_monitor_unit.sv
// Flow: an accepted item is registered in item_ff and checked, and its result
// is registered in result_ff, which drives the rsp_ outputs.
// Throughput: one item per cycle unless rsp_stall holds a full result; a group's
// slope state is read and rewritten in the same cycle the check enters result_ff.
// Reset: clears both valid flags and the slope armed flags, and returns the
// registers to zero thresholds, periods and rises with the open code -32768.
// ----------------------------------------------------------------------------
// Thermal group safety monitor unit
// Periodic safety checks of two heater groups, one item per cycle unless stalled.
// ----------------------------------------------------------------------------
module thermal_group_safety_monitor_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_group,
   input  logic signed [15:0] req_temperature,
   input  logic [2:0]         req_mode_in,
   input  logic               req_heat_drive,
   input  logic               req_heater_present,
   input  logic [31:0]        req_sample_time,
   input  logic [31:0]        req_now_tick,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_sensor_valid,
   output logic               rsp_device_is_heater,
   output logic [2:0]         rsp_mode_out,
   output logic               rsp_open_fault,
   output logic               rsp_timeout_fault,
   output logic               rsp_wake_control,
   output logic               rsp_slope_fault,
   output logic               rsp_threshold_fault,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_write_data
);

   tgsm_pkg::cfg_type          cfg;
   tgsm_pkg::item_type         item_ff;
   tgsm_pkg::item_type         item_in;
   tgsm_pkg::result_type       result_ff;
   tgsm_pkg::result_type       result_in;
   tgsm_pkg::slope_state_type  slope_state;
   tgsm_pkg::slope_update_type slope_update;
   logic                       item_valid_ff;
   logic                       rsp_valid_ff;
   logic                       advance;
   logic                       accept;

   tgsm_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // The result register takes a new item when empty or being drained.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = item_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign item_in.group          = req_group;
   assign item_in.temperature    = req_temperature;
   assign item_in.mode_in        = req_mode_in;
   assign item_in.heat_drive     = req_heat_drive;
   assign item_in.heater_present = req_heater_present;
   assign item_in.sample_time    = req_sample_time;
   assign item_in.now_tick       = req_now_tick;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         item_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   tgsm_slope u_slope (
      .clock  (clock),
      .reset  (reset),
      .commit (item_valid_ff && advance),
      .group  (item_ff.group),
      .update (slope_update),
      .state  (slope_state)
   );

   tgsm_check u_check (
      .item   (item_ff),
      .cfg    (cfg),
      .slope  (slope_state),
      .result (result_in),
      .update (slope_update)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= item_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && item_valid_ff) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_sensor_valid     = result_ff.sensor_valid;
   assign rsp_device_is_heater = result_ff.device_is_heater;
   assign rsp_mode_out         = result_ff.mode_out;
   assign rsp_open_fault       = result_ff.open_fault;
   assign rsp_timeout_fault    = result_ff.timeout_fault;
   assign rsp_wake_control     = result_ff.wake_control;
   assign rsp_slope_fault      = result_ff.slope_fault;
   assign rsp_threshold_fault  = result_ff.threshold_fault;

`ifndef NO_ASSERTIONS
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (item_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled while the result register could drain");

   a_fault_forces_fanon: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_open_fault || rsp_timeout_fault || rsp_slope_fault
                     || rsp_threshold_fault))
      |-> (rsp_mode_out == tgsm_pkg::MODE_FANON))
      else $error("fault reported without fan-on mode");

   a_wake_excludes_timeout: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_wake_control && rsp_timeout_fault))
      else $error("wake and timeout reported together");

   a_peltier_never_auto: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_device_is_heater) |-> (rsp_mode_out != tgsm_pkg::MODE_HEAT_AUTO))
      else $error("auto mode on a peltier group");
`endif

endmodule
